/* rtl/res_pkg.sv */
package res_pkg;
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DEL,
    ST_EMIT
  } res_state_e;

  typedef struct packed {
    logic shift;
    logic del_en;
    logic emit;
  } res_ctrl_t;
endpackage

/* rtl/res_cell.sv */
module res_cell #(
  parameter int unsigned IDX_W = 12,
  parameter int unsigned ERR_W = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  res_pkg::res_ctrl_t      ctrl_i,
  input  logic                    at_del_i,
  input  logic                    past_del_i,
  input  logic                    load_i,
  input  logic [IDX_W-1:0]        load_idx_i,
  input  logic signed [ERR_W-1:0] load_err_i,
  input  logic [IDX_W-1:0]        next_idx_i,
  input  logic signed [ERR_W-1:0] next_err_i,
  output logic [IDX_W-1:0]        idx_o,
  output logic signed [ERR_W-1:0] err_o
);
  import res_pkg::*;

  logic [IDX_W-1:0]        idx_q;
  logic signed [ERR_W-1:0] err_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      idx_q <= load_idx_i;
      err_q <= load_err_i;
    end else if (ctrl_i.emit || (ctrl_i.del_en && (at_del_i || past_del_i))) begin
      idx_q <= next_idx_i;
      err_q <= next_err_i;
    end
  end

  assign idx_o = idx_q;
  assign err_o = err_q;

  logic unused;
  assign unused = ctrl_i.shift ^ rst_ni;
endmodule

/* rtl/remez_extremum_search_core.sv */
// Samples are taken one per cycle while busy is low; a run's last sample raises busy.
// Each deletion step scans the list entry by entry, reading each entry and then comparing
// it, then reads and decides which entry to delete and deletes it in ST_DEL. A scan that finds
// the list short enough starts emission: half_order+1 results follow on consecutive cycles and busy drops.
// Asynchronous active-low reset clears run state; half_order resets to 16.
// Results are strobed for one cycle; the receiver cannot stall.
module remez_extremum_search_core #(
  parameter int unsigned GRID_MAX  = 4096,
  parameter int unsigned FOUND_MAX = 128,
  parameter int unsigned ERR_WIDTH = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [ERR_WIDTH-1:0] error_value_i,
  input  logic                        last_sample_i,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [5:0]                  cfg_data,
  output logic                        strobe,
  output logic [11:0]                 extremum_index_o,
  output logic signed [ERR_WIDTH-1:0] extremum_error_o,
  output logic                        last_extremum_o,
  output logic                        too_few_o,
  output logic                        list_overflow_o
);
  import res_pkg::*;

  localparam int unsigned IW = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;
  localparam int unsigned NW = $clog2(GRID_MAX + 1);
  localparam int unsigned FW = $clog2(FOUND_MAX + 1);
  localparam int unsigned PW = $clog2(FOUND_MAX);
  localparam int unsigned OW = 12;

  res_state_e state_q, state_d;
  logic [5:0] ho_q;
  logic [NW-1:0] n_q;
  logic signed [ERR_WIDTH-1:0] p_q, pp_q;
  logic [FW-1:0] k_q;
  logic ovf_q;
  logic [FW-1:0] j_q, del_q;
  logic up_q, alt_q;
  logic [ERR_WIDTH-1:0] dmag_q;
  logic [6:0] emit_q;
  logic rd_q;
  logic signed [ERR_WIDTH-1:0] ej_q, ekl_q;

  logic [IW-1:0]        idx_a [FOUND_MAX];
  logic signed [ERR_WIDTH-1:0] err_a [FOUND_MAX];
  logic [IW-1:0]        nidx  [FOUND_MAX];
  logic signed [ERR_WIDTH-1:0] nerr  [FOUND_MAX];

  res_ctrl_t ctrl;
  logic [6:0] target;
  assign target = {1'b0, ho_q} + 7'd1;

  logic accept, last, rec, rec_last;
  logic [IW-1:0] rec_idx;
  logic signed [ERR_WIDTH-1:0] rec_err;
  logic signed [ERR_WIDTH-1:0] e;
  assign e = error_value_i;
  assign accept = start && !busy;
  assign last = last_sample_i || (n_q >= NW'(GRID_MAX - 1));

  always_comb begin
    rec = 1'b0;
    rec_idx = '0;
    rec_err = p_q;
    if (n_q == NW'(1) && ((p_q > 0 && p_q > e) || (p_q < 0 && p_q < e))) begin
      rec = 1'b1;
    end
    if (n_q >= NW'(2) && ((p_q >= pp_q && p_q > e && p_q > 0) ||
                          (p_q <= pp_q && p_q < e && p_q < 0))) begin
      rec = 1'b1;
      rec_idx = IW'(n_q - NW'(1));
    end
    rec_last = last && n_q >= NW'(1) && ((e > 0 && e > p_q) || (e < 0 && e < p_q));
  end

  // load position for recorded extremum(s)
  logic [FW-1:0] k1;
  assign k1 = k_q + FW'(rec && k_q < FW'(FOUND_MAX));

  function automatic logic [ERR_WIDTH-1:0] mag(input logic signed [ERR_WIDTH-1:0] v);
    mag = v[ERR_WIDTH-1] ? ERR_WIDTH'(-v) : v;
  endfunction

  logic [PW-1:0] jp, kl;
  assign jp = j_q[PW-1:0];
  assign kl = PW'(k_q - FW'(1));

  always_comb begin
    state_d = state_q;
    ctrl = '0;
    unique case (state_q)
      ST_LOAD: if (accept && last) state_d = ST_SCAN;
      ST_SCAN: begin
        if (k_q <= FW'(target)) state_d = ST_EMIT;
        else if (rd_q && (j_q >= k_q || !alt_q)) state_d = ST_DEL;
      end
      ST_DEL: begin
        ctrl.del_en = 1'b1;
        state_d = ST_SCAN;
      end
      ST_EMIT: begin
        ctrl.emit = 1'b1;
        if (emit_q + 7'd1 == target) state_d = ST_LOAD;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  assign busy = (state_q != ST_LOAD);
  assign cfg_ready = !busy;

  genvar g;
  generate
    for (g = 0; g < FOUND_MAX; g++) begin : g_row
      logic ld;
      logic [IW-1:0] li;
      logic signed [ERR_WIDTH-1:0] le;
      always_comb begin
        ld = 1'b0;
        li = rec_idx;
        le = rec_err;
        if (state_q == ST_LOAD && accept) begin
          if (rec && k_q == FW'(g)) ld = 1'b1;
          else if (rec_last && k1 == FW'(g)) begin
            ld = 1'b1;
            li = IW'(n_q);
            le = e;
          end
        end
      end
      if (g + 1 < FOUND_MAX) begin : g_n
        assign nidx[g] = idx_a[g+1];
        assign nerr[g] = err_a[g+1];
      end else begin : g_e
        assign nidx[g] = '0;
        assign nerr[g] = '0;
      end
      res_cell #(.IDX_W(IW), .ERR_W(ERR_WIDTH)) u_cell (
        .clk_i, .rst_ni, .ctrl_i(ctrl),
        .at_del_i(del_q == FW'(g)), .past_del_i(del_q < FW'(g)),
        .load_i(ld), .load_idx_i(li), .load_err_i(le),
        .next_idx_i(nidx[g]), .next_err_i(nerr[g]),
        .idx_o(idx_a[g]), .err_o(err_a[g])
      );
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      ho_q <= 6'd16;
      n_q <= '0; p_q <= '0; pp_q <= '0; k_q <= '0; ovf_q <= 1'b0;
      j_q <= '0; del_q <= '0; up_q <= 1'b0; alt_q <= 1'b1; dmag_q <= '0;
      emit_q <= '0; rd_q <= 1'b0; ej_q <= '0; ekl_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid && cfg_ready) ho_q <= cfg_data;
      unique case (state_q)
        ST_LOAD: if (accept) begin
          logic [FW-1:0] kn;
          logic o;
          logic u;
          logic [ERR_WIDTH-1:0] dm;
          kn = k_q; o = ovf_q; u = 1'b0; dm = '0;
          if (rec) begin
            if (kn < FW'(FOUND_MAX)) kn = kn + FW'(1); else o = 1'b1;
          end
          if (rec_last) begin
            if (kn < FW'(FOUND_MAX)) kn = kn + FW'(1); else o = 1'b1;
          end
          if (last) begin
            u = err_a[0] > 0;
            dm = mag(err_a[0]);
            if (rec && k_q == '0) begin
              u = rec_err > 0; dm = mag(rec_err);
            end else if (rec_last && k1 == '0) begin
              u = e > 0; dm = mag(e);
            end
          end
          k_q <= kn; ovf_q <= o;
          pp_q <= p_q; p_q <= e; n_q <= n_q + NW'(1);
          j_q <= FW'(1); del_q <= '0; alt_q <= 1'b1;
          up_q <= u; dmag_q <= dm; rd_q <= 1'b0;
        end
        ST_SCAN: if (k_q > FW'(target)) begin
          if (!rd_q) begin
            ej_q <= err_a[jp];
            ekl_q <= err_a[kl];
            rd_q <= 1'b1;
          end else begin
            rd_q <= 1'b0;
            if (j_q >= k_q || !alt_q) begin
              if (alt_q && (k_q - FW'(target)) == FW'(1))
                del_q <= (mag(ekl_q) < mag(err_a[0])) ? FW'(kl) : '0;
            end else begin
              if (mag(ej_q) < dmag_q) begin
                dmag_q <= mag(ej_q); del_q <= j_q;
              end
              if (up_q && ej_q < 0) up_q <= 1'b0;
              else if (!up_q && ej_q > 0) up_q <= 1'b1;
              else alt_q <= 1'b0;
              j_q <= j_q + FW'(1);
            end
          end
        end
        ST_DEL: begin
          k_q <= k_q - FW'(1);
          j_q <= FW'(1); alt_q <= 1'b1; rd_q <= 1'b0;
          // first entry after shift
          up_q <= (del_q == '0) ? err_a[1] > 0 : err_a[0] > 0;
          dmag_q <= (del_q == '0) ? mag(err_a[1]) : mag(err_a[0]);
          del_q <= '0; emit_q <= '0;
        end
        ST_EMIT: begin
          if (emit_q + 7'd1 == target) begin
            n_q <= '0; p_q <= '0; pp_q <= '0; k_q <= '0; ovf_q <= 1'b0;
            emit_q <= '0;
          end else begin
            emit_q <= emit_q + 7'd1;
          end
        end
        default: ;
      endcase
    end
  end

  logic [6:0] outn;
  assign outn = emit_q;
  assign strobe = (state_q == ST_EMIT);
  assign extremum_index_o = ({1'b0, outn} < 8'(k_q)) ? OW'(idx_a[0]) : '0;
  assign extremum_error_o = ({1'b0, outn} < 8'(k_q)) ? err_a[0] : '0;
  assign last_extremum_o = (outn + 7'd1 == target);
  assign too_few_o = k_q < FW'(target);
  assign list_overflow_o = ovf_q;
endmodule

/* rtl/res_checker.sv */
module res_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic busy,
  input logic strobe,
  input logic last_extremum_o,
  input logic cfg_ready
);
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe |-> busy) else $error("strobe while idle");
  a_last_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && last_extremum_o |=> !strobe) else $error("strobe after last");
  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready |-> !busy) else $error("cfg while busy");
endmodule

bind remez_extremum_search_core res_checker u_chk (.*);
